[hdl/assert_macros.svh]
// Assertion macros for the closest-point datapath modules (used by cps_back).
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// ante true implies cons at the same edge
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

[hdl/cps_pkg.sv]
// Shared constants, region codes and width helpers for the closest-point core.
// No dependencies.
package cps_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int DIR_FRAC_BITS_DEF = 14;
    localparam int DIR_BITS          = 16;
    localparam int HALF_BITS         = 20;
    localparam int REGION_BITS       = 2;

    typedef enum logic [REGION_BITS-1:0] {
        REG_START    = 2'd0,
        REG_INTERIOR = 2'd1,
        REG_END      = 2'd2
    } t_region;

    // rounded h*dir, Q.8
    function automatic int hd_width(input int fb);
        return HALF_BITS + 1 + DIR_BITS - fb;
    endfunction

    // v = point - centre + hd
    function automatic int v_width(input int cb, input int fb);
        int a;
        int b;
        a = cb + 1;
        b = hd_width(fb);
        return ((a > b) ? a : b) + 1;
    endfunction

    // projection t restricted to the interior range [0, 2h << fb]
    function automatic int ti_width(input int fb);
        return HALF_BITS + 1 + fb;
    endfunction

endpackage

[hdl/cps_if.sv]
// Valid/ready channel interfaces for the query and result streams.
// Depends on cps_pkg.
interface cps_in_if #(
    parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) ();
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_BITS-1:0]           point_x;
    logic signed [COORD_BITS-1:0]           point_y;
    logic signed [COORD_BITS-1:0]           point_z;
    logic signed [COORD_BITS-1:0]           centre_x;
    logic signed [COORD_BITS-1:0]           centre_y;
    logic signed [COORD_BITS-1:0]           centre_z;
    logic signed [cps_pkg::DIR_BITS-1:0]    dir_x;
    logic signed [cps_pkg::DIR_BITS-1:0]    dir_y;
    logic signed [cps_pkg::DIR_BITS-1:0]    dir_z;
    logic        [cps_pkg::HALF_BITS-1:0]   half_length;

    modport source (
        output valid, point_x, point_y, point_z, centre_x, centre_y, centre_z,
               dir_x, dir_y, dir_z, half_length,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, centre_x, centre_y, centre_z,
               dir_x, dir_y, dir_z, half_length,
        output ready
    );
endinterface

interface cps_out_if #(
    parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) ();
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_BITS+1:0]           disp_x;
    logic signed [COORD_BITS+1:0]           disp_y;
    logic signed [COORD_BITS+1:0]           disp_z;
    logic        [cps_pkg::REGION_BITS-1:0] region;

    modport source (
        output valid, disp_x, disp_y, disp_z, region,
        input  ready
    );
    modport sink (
        input  valid, disp_x, disp_y, disp_z, region,
        output ready
    );
endinterface

[hdl/closest_point_on_segment_core.sv]
// Closest point on a 3-D segment: seven register stages, one query per cycle.
// Throughput: 1 query per cycle; a stall only blocks when every stage holds an item.
// Longest stage: one 26x16 multiply for the v.dir products (at the default COORD_BITS).
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data is not reset.
// Depends on cps_pkg, cps_if, cps_front, cps_proj, cps_back.
module closest_point_on_segment_core #(
    parameter int COORD_BITS    = cps_pkg::COORD_BITS_DEF,
    parameter int DIR_FRAC_BITS = cps_pkg::DIR_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cps_in_if.sink     i_in,
    cps_out_if.source  o_out
);

    localparam int DB   = cps_pkg::DIR_BITS;
    localparam int HB   = cps_pkg::HALF_BITS;
    localparam int HD_W = cps_pkg::hd_width(DIR_FRAC_BITS);
    localparam int V_W  = cps_pkg::v_width(COORD_BITS, DIR_FRAC_BITS);
    localparam int TI_W = cps_pkg::ti_width(DIR_FRAC_BITS);

    logic                  f_valid, p_ready;
    logic [2:0][V_W-1:0]   f_v;
    logic [2:0][HD_W-1:0]  f_hd;
    logic [2:0][DB-1:0]    f_d;
    logic [HB-1:0]         f_h;

    logic                  p_valid, b_ready;
    logic [2:0][V_W-1:0]   p_v;
    logic [2:0][HD_W-1:0]  p_hd;
    logic [2:0][DB-1:0]    p_d;
    logic [TI_W-1:0]       p_ti;
    cps_pkg::t_region      p_region;

    cps_front #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (p_ready),
        .o_v     (f_v),
        .o_hd    (f_hd),
        .o_d     (f_d),
        .o_h     (f_h)
    );

    cps_proj #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_proj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (p_ready),
        .i_v      (f_v),
        .i_hd     (f_hd),
        .i_d      (f_d),
        .i_h      (f_h),
        .o_valid  (p_valid),
        .i_ready  (b_ready),
        .o_v      (p_v),
        .o_hd     (p_hd),
        .o_d      (p_d),
        .o_ti     (p_ti),
        .o_region (p_region)
    );

    cps_back #(
        .COORD_BITS    (COORD_BITS),
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (p_valid),
        .o_ready  (b_ready),
        .i_v      (p_v),
        .i_hd     (p_hd),
        .i_d      (p_d),
        .i_ti     (p_ti),
        .i_region (p_region),
        .o_out    (o_out)
    );

endmodule

[hdl/cps_front.sv]
// Front two stages: point-centre difference and h*dir, then rounding to hd and v.
// Depends on cps_pkg and cps_in_if.
module cps_front #(
    parameter int  COORD_BITS    = cps_pkg::COORD_BITS_DEF,
    parameter int  DIR_FRAC_BITS = cps_pkg::DIR_FRAC_BITS_DEF,
    localparam int DB            = cps_pkg::DIR_BITS,
    localparam int HB            = cps_pkg::HALF_BITS,
    localparam int HD_W          = cps_pkg::hd_width(DIR_FRAC_BITS),
    localparam int V_W           = cps_pkg::v_width(COORD_BITS, DIR_FRAC_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    cps_in_if.sink                 i_in,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0][V_W-1:0]    o_v,
    output logic [2:0][HD_W-1:0]   o_hd,
    output logic [2:0][DB-1:0]     o_d,
    output logic [HB-1:0]          o_h
);

    localparam int PC_W  = COORD_BITS + 1;
    localparam int HDP_W = HB + 1 + DB;
    localparam logic signed [HDP_W-1:0] HD_HALF = HDP_W'(1) << (DIR_FRAC_BITS - 1);

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] c [3];
    logic signed [DB-1:0]         d [3];

    logic                    r_vld0, r_vld1;
    logic                    en0, en1;
    logic signed [PC_W-1:0]  r_pc  [3];
    logic signed [PC_W-1:0]  n_pc  [3];
    logic signed [HDP_W-1:0] r_hdp [3];
    logic signed [HDP_W-1:0] n_hdp [3];
    logic signed [DB-1:0]    r_d0  [3];
    logic [HB-1:0]           r_h0;

    logic signed [HDP_W-1:0] hs [3];
    logic signed [HDP_W-1:0] hf [3];
    logic signed [HD_W-1:0]  n_hd [3];
    logic signed [V_W-1:0]   n_v  [3];
    logic signed [HD_W-1:0]  r_hd [3];
    logic signed [V_W-1:0]   r_v  [3];
    logic signed [DB-1:0]    r_d1 [3];
    logic [HB-1:0]           r_h1;

    assign en1        = !r_vld1 || i_ready;
    assign en0        = !r_vld0 || en1;
    assign i_in.ready = en0;
    assign o_valid    = r_vld1;
    assign o_h        = r_h1;

    always_comb begin
        p[0] = i_in.point_x;
        p[1] = i_in.point_y;
        p[2] = i_in.point_z;
        c[0] = i_in.centre_x;
        c[1] = i_in.centre_y;
        c[2] = i_in.centre_z;
        d[0] = i_in.dir_x;
        d[1] = i_in.dir_y;
        d[2] = i_in.dir_z;
        for (int i = 0; i < 3; i++) begin
            n_pc[i]  = PC_W'(p[i]) - PC_W'(c[i]);
            n_hdp[i] = $signed({1'b0, i_in.half_length}) * d[i];
        end
    end

    // round half up: add half an LSB, arithmetic shift floors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hs[i]   = r_hdp[i] + HD_HALF;
            hf[i]   = hs[i] >>> DIR_FRAC_BITS;
            n_hd[i] = hf[i][HD_W-1:0];
            n_v[i]  = V_W'(r_pc[i]) + V_W'(n_hd[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_v[i]  = r_v[i];
            o_hd[i] = r_hd[i];
            o_d[i]  = r_d1[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (en0) r_vld0 <= i_in.valid;
            if (en1) r_vld1 <= r_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_pc  <= n_pc;
            r_hdp <= n_hdp;
            r_d0  <= d;
            r_h0  <= i_in.half_length;
        end
        if (en1) begin
            r_v  <= n_v;
            r_hd <= n_hd;
            r_d1 <= r_d0;
            r_h1 <= r_h0;
        end
    end

endmodule

[hdl/cps_proj.sv]
// Middle two stages: per-axis v*dir products, then the dot product and region test.
// Depends on cps_pkg.
module cps_proj #(
    parameter int  COORD_BITS    = cps_pkg::COORD_BITS_DEF,
    parameter int  DIR_FRAC_BITS = cps_pkg::DIR_FRAC_BITS_DEF,
    localparam int DB            = cps_pkg::DIR_BITS,
    localparam int HB            = cps_pkg::HALF_BITS,
    localparam int HD_W          = cps_pkg::hd_width(DIR_FRAC_BITS),
    localparam int V_W           = cps_pkg::v_width(COORD_BITS, DIR_FRAC_BITS),
    localparam int TI_W          = cps_pkg::ti_width(DIR_FRAC_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0][V_W-1:0]    i_v,
    input  logic [2:0][HD_W-1:0]   i_hd,
    input  logic [2:0][DB-1:0]     i_d,
    input  logic [HB-1:0]          i_h,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [2:0][V_W-1:0]    o_v,
    output logic [2:0][HD_W-1:0]   o_hd,
    output logic [2:0][DB-1:0]     o_d,
    output logic [TI_W-1:0]        o_ti,
    output cps_pkg::t_region       o_region
);

    localparam int VD_W  = V_W + DB;
    localparam int T_W   = VD_W + 2;
    localparam int LIM_W = TI_W + 1;
    localparam int CMP_W = (T_W > LIM_W) ? T_W : LIM_W;

    logic                    r_vld3, r_vld4;
    logic                    en3, en4;
    logic signed [V_W-1:0]   v_in [3];
    logic signed [DB-1:0]    d_in [3];
    logic signed [VD_W-1:0]  n_vd [3];
    logic signed [VD_W-1:0]  r_vd [3];
    logic [2:0][V_W-1:0]     r_v3;
    logic [2:0][HD_W-1:0]    r_hd3;
    logic [2:0][DB-1:0]      r_d3;
    logic [HB-1:0]           r_h3;

    logic signed [T_W-1:0]   t;
    logic signed [CMP_W-1:0] t_ext;
    logic [TI_W-1:0]         lim;
    logic signed [CMP_W-1:0] lim_ext;
    cps_pkg::t_region        n_region;
    logic [TI_W-1:0]         n_ti;

    logic [2:0][V_W-1:0]     r_v4;
    logic [2:0][HD_W-1:0]    r_hd4;
    logic [2:0][DB-1:0]      r_d4;
    logic [TI_W-1:0]         r_ti;
    cps_pkg::t_region        r_region;

    assign en4      = !r_vld4 || i_ready;
    assign en3      = !r_vld3 || en4;
    assign o_ready  = en3;
    assign o_valid  = r_vld4;
    assign o_v      = r_v4;
    assign o_hd     = r_hd4;
    assign o_d      = r_d4;
    assign o_ti     = r_ti;
    assign o_region = r_region;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_in[i] = $signed(i_v[i]);
            d_in[i] = $signed(i_d[i]);
            n_vd[i] = v_in[i] * d_in[i];
        end
    end

    // t in Q.(8+F); interior only when 0 <= t <= 2h << F
    always_comb begin
        t       = T_W'(r_vd[0]) + T_W'(r_vd[1]) + T_W'(r_vd[2]);
        t_ext   = CMP_W'(t);
        lim     = {r_h3, (DIR_FRAC_BITS + 1)'(0)};
        lim_ext = $signed(CMP_W'(lim));
        if (t_ext[CMP_W-1]) begin
            n_region = cps_pkg::REG_START;
        end else if (t_ext > lim_ext) begin
            n_region = cps_pkg::REG_END;
        end else begin
            n_region = cps_pkg::REG_INTERIOR;
        end
        n_ti = t_ext[TI_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en3) r_vld3 <= i_valid;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_vd  <= n_vd;
            r_v3  <= i_v;
            r_hd3 <= i_hd;
            r_d3  <= i_d;
            r_h3  <= i_h;
        end
        if (en4) begin
            r_v4     <= r_v3;
            r_hd4    <= r_hd3;
            r_d4     <= r_d3;
            r_ti     <= n_ti;
            r_region <= n_region;
        end
    end

endmodule

[hdl/cps_back.sv]
// Back three stages: t*dir as two partial products, rounding, then region select
// and saturation into the output register. Depends on cps_pkg, cps_out_if, assert_macros.svh.
`include "assert_macros.svh"

module cps_back #(
    parameter int  COORD_BITS    = cps_pkg::COORD_BITS_DEF,
    parameter int  DIR_FRAC_BITS = cps_pkg::DIR_FRAC_BITS_DEF,
    localparam int DB            = cps_pkg::DIR_BITS,
    localparam int HD_W          = cps_pkg::hd_width(DIR_FRAC_BITS),
    localparam int V_W           = cps_pkg::v_width(COORD_BITS, DIR_FRAC_BITS),
    localparam int TI_W          = cps_pkg::ti_width(DIR_FRAC_BITS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [2:0][V_W-1:0]    i_v,
    input  logic [2:0][HD_W-1:0]   i_hd,
    input  logic [2:0][DB-1:0]     i_d,
    input  logic [TI_W-1:0]        i_ti,
    input  cps_pkg::t_region       i_region,
    cps_out_if.source              o_out
);

    localparam int TL_W = TI_W / 2;
    localparam int TH_W = TI_W - TL_W;
    localparam int PL_W = TL_W + 1 + DB;
    localparam int PH_W = TH_W + 1 + DB;
    localparam int P_W  = TI_W + 1 + DB;
    localparam int PS_W = P_W + 1;
    localparam int Q_W  = PS_W - 2 * DIR_FRAC_BITS;
    localparam int R_W  = V_W + 2;
    localparam int O_W  = COORD_BITS + 2;
    localparam logic signed [PS_W-1:0] Q_HALF = PS_W'(1) << (2 * DIR_FRAC_BITS - 1);
    localparam logic signed [R_W-1:0]  SAT_HI = R_W'((64'(1) << (O_W - 1)) - 64'(1));
    localparam logic signed [R_W-1:0]  SAT_LO = ~SAT_HI;

    logic                    r_vld5, r_vld6, r_vld7;
    logic                    en5, en6, en7;

    logic signed [DB-1:0]    d_in [3];
    logic [TL_W-1:0]         t_lo;
    logic [TH_W-1:0]         t_hi;
    logic signed [PL_W-1:0]  n_plo [3];
    logic signed [PH_W-1:0]  n_phi [3];
    logic signed [PL_W-1:0]  r_plo [3];
    logic signed [PH_W-1:0]  r_phi [3];
    logic [2:0][V_W-1:0]     r_v5;
    logic [2:0][HD_W-1:0]    r_hd5;
    cps_pkg::t_region        r_reg5;

    logic signed [P_W-1:0]   pf [3];
    logic signed [PS_W-1:0]  ps [3];
    logic signed [PS_W-1:0]  qf [3];
    logic signed [Q_W-1:0]   n_q [3];
    logic signed [Q_W-1:0]   r_q [3];
    logic [2:0][V_W-1:0]     r_v6;
    logic [2:0][HD_W-1:0]    r_hd6;
    cps_pkg::t_region        r_reg6;

    logic signed [V_W-1:0]   v6 [3];
    logic signed [HD_W-1:0]  hd6 [3];
    logic signed [R_W-1:0]   res [3];
    logic signed [O_W-1:0]   n_disp [3];
    logic signed [O_W-1:0]   r_disp [3];
    cps_pkg::t_region        r_reg7;

    assign en7     = !r_vld7 || o_out.ready;
    assign en6     = !r_vld6 || en7;
    assign en5     = !r_vld5 || en6;
    assign o_ready = en5;

    assign o_out.valid  = r_vld7;
    assign o_out.disp_x = r_disp[0];
    assign o_out.disp_y = r_disp[1];
    assign o_out.disp_z = r_disp[2];
    assign o_out.region = r_reg7;

    // interior t is non-negative, so both halves multiply as unsigned by signed dir
    always_comb begin
        t_lo = i_ti[TL_W-1:0];
        t_hi = i_ti[TI_W-1:TL_W];
        for (int i = 0; i < 3; i++) begin
            d_in[i]  = $signed(i_d[i]);
            n_plo[i] = $signed({1'b0, t_lo}) * d_in[i];
            n_phi[i] = $signed({1'b0, t_hi}) * d_in[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pf[i]  = (P_W'(r_phi[i]) <<< TL_W) + P_W'(r_plo[i]);
            ps[i]  = PS_W'(pf[i]) + Q_HALF;
            qf[i]  = ps[i] >>> (2 * DIR_FRAC_BITS);
            n_q[i] = qf[i][Q_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v6[i]  = $signed(r_v6[i]);
            hd6[i] = $signed(r_hd6[i]);
            case (r_reg6)
                cps_pkg::REG_START: res[i] = R_W'(v6[i]);
                cps_pkg::REG_END:   res[i] = R_W'(v6[i]) - (R_W'(hd6[i]) <<< 1);
                default:            res[i] = R_W'(v6[i]) - R_W'(r_q[i]);
            endcase
            if (res[i] > SAT_HI) begin
                n_disp[i] = SAT_HI[O_W-1:0];
            end else if (res[i] < SAT_LO) begin
                n_disp[i] = SAT_LO[O_W-1:0];
            end else begin
                n_disp[i] = res[i][O_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
        end else begin
            if (en5) r_vld5 <= i_valid;
            if (en6) r_vld6 <= r_vld5;
            if (en7) r_vld7 <= r_vld6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_plo  <= n_plo;
            r_phi  <= n_phi;
            r_v5   <= i_v;
            r_hd5  <= i_hd;
            r_reg5 <= i_region;
        end
        if (en6) begin
            r_q    <= n_q;
            r_v6   <= r_v5;
            r_hd6  <= r_hd5;
            r_reg6 <= r_reg5;
        end
        if (en7) begin
            r_disp <= n_disp;
            r_reg7 <= r_reg6;
        end
    end

    // a stalled item stays put, a moving one lands downstream, a transfer in fills stage 5
    `ASSERT_NEXT(a_hold5, i_clk, i_rst_n, r_vld5 && !en6, r_vld5 && $stable(r_reg5))
    `ASSERT_NEXT(a_move6, i_clk, i_rst_n, r_vld6 && en7, r_vld7)
    `ASSERT_NEXT(a_take5, i_clk, i_rst_n, i_valid && o_ready, r_vld5)

endmodule

[tb/testbench.sv]
// Self-checking testbench for closest_point_on_segment_core: a directed table, then random
// queries checked against a behavioral predictor, under several handshake pacing phases.
// Depends on cps_pkg, cps_if and the core RTL.
module testbench;
    import cps_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int FRAC_BITS   = DIR_FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    localparam longint CMAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;
    localparam longint HMAX = (longint'(1) <<< HALF_BITS) - 1;
    localparam longint UNIT = longint'(1) <<< FRAC_BITS;

    typedef enum int {
        PACE_FREE,
        PACE_SENDER_GAPS,
        PACE_SINK_STALLS,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] point;
        logic [2:0][COORD_BITS-1:0] centre;
        logic [2:0][DIR_BITS-1:0]   dir;
        logic [HALF_BITS-1:0]       half;
    } t_seg_query;

    typedef struct packed {
        logic [2:0][COORD_BITS+1:0] disp;
        t_region                    region;
    } t_seg_disp;

    typedef struct {
        t_seg_query query;
        bit         known;
        t_seg_disp  want;
    } t_probe_row;

    logic i_clk;
    logic i_rst_n;

    cps_in_if  #(.COORD_BITS(COORD_BITS)) query_ch ();
    cps_out_if #(.COORD_BITS(COORD_BITS)) disp_ch ();

    closest_point_on_segment_core #(
        .COORD_BITS   (COORD_BITS),
        .DIR_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (query_ch),
        .o_out  (disp_ch)
    );

    t_seg_disp  disp_due[$];
    t_probe_row probe_rows[$];
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         cycles_run = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    bit         hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // floor((x + 2^(s-1)) / 2^s): round half up
    function automatic longint round_up_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [COORD_BITS+1:0] clamp_disp(input longint x);
        longint top;
        top = (longint'(1) <<< (COORD_BITS + 1)) - 1;
        if (x > top)
            x = top;
        else if (x < -top - 1)
            x = -top - 1;
        return x[COORD_BITS+1:0];
    endfunction

    function automatic t_seg_disp nearest_disp(input t_seg_query q);
        t_seg_disp r;
        longint    h;
        longint    lim;
        longint    t;
        longint    d[3];
        longint    hd[3];
        longint    v[3];
        longint    w[3];
        int        i;
        h   = longint'(q.half);
        lim = (2 * h) <<< FRAC_BITS;
        t   = 0;
        for (i = 0; i < 3; i++) begin
            d[i]  = longint'($signed(q.dir[i]));
            hd[i] = round_up_shift(h * d[i], FRAC_BITS);
            v[i]  = longint'($signed(q.point[i])) - longint'($signed(q.centre[i])) + hd[i];
            t    += v[i] * d[i];
        end
        for (i = 0; i < 3; i++) begin
            if (t < 0)
                w[i] = v[i];
            else if (t > lim)
                w[i] = v[i] - 2 * hd[i];
            else
                w[i] = v[i] - round_up_shift(t * d[i], 2 * FRAC_BITS);
            r.disp[i] = clamp_disp(w[i]);
        end
        if (t < 0)
            r.region = REG_START;
        else if (t > lim)
            r.region = REG_END;
        else
            r.region = REG_INTERIOR;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_seg_query make_query(input longint px, py, pz, cx, cy, cz,
                                              dx, dy, dz, h);
        t_seg_query q;
        q.point[0]  = px[COORD_BITS-1:0];
        q.point[1]  = py[COORD_BITS-1:0];
        q.point[2]  = pz[COORD_BITS-1:0];
        q.centre[0] = cx[COORD_BITS-1:0];
        q.centre[1] = cy[COORD_BITS-1:0];
        q.centre[2] = cz[COORD_BITS-1:0];
        q.dir[0]    = dx[DIR_BITS-1:0];
        q.dir[1]    = dy[DIR_BITS-1:0];
        q.dir[2]    = dz[DIR_BITS-1:0];
        q.half      = h[HALF_BITS-1:0];
        return q;
    endfunction

    function automatic t_probe_row predicted_row(input t_seg_query q);
        t_probe_row row;
        row.query = q;
        row.known = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic t_probe_row known_row(input t_seg_query q, input longint x, y, z,
                                             input t_region reg_code);
        t_probe_row row;
        row.query       = q;
        row.known       = 1'b1;
        row.want.disp[0] = x[COORD_BITS+1:0];
        row.want.disp[1] = y[COORD_BITS+1:0];
        row.want.disp[2] = z[COORD_BITS+1:0];
        row.want.region  = reg_code;
        return row;
    endfunction

    function automatic void add_probe(input t_probe_row row);
        probe_rows.insert(probe_rows.size(), row);
    endfunction

    function automatic void queue_result(input t_seg_disp want);
        disp_due.insert(disp_due.size(), want);
    endfunction

    // Mostly unit directions with the point placed near the segment so that all
    // three regions show up; the rest is raw noise over every field bit.
    function automatic t_seg_query random_query();
        t_seg_query q;
        longint     h;
        longint     span;
        longint     off;
        int         pick;
        int         k;
        int         i;
        if ($urandom_range(0, 99) < 20) begin
            for (i = 0; i < 3; i++) begin
                q.point[i]  = COORD_BITS'($urandom);
                q.centre[i] = COORD_BITS'($urandom);
                q.dir[i]    = DIR_BITS'($urandom);
            end
            q.half = HALF_BITS'($urandom);
            return q;
        end
        pick = $urandom_range(0, 3);
        k    = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
            q.dir[i] = '0;
        case (pick)
            0: begin
                q.dir[k] = DIR_BITS'(UNIT);
            end
            1: begin
                q.dir[k]           = DIR_BITS'(11585);
                q.dir[(k + 1) % 3] = DIR_BITS'(11585);
            end
            2: begin
                for (i = 0; i < 3; i++)
                    q.dir[i] = DIR_BITS'(9459);
            end
            default: begin
                // not normalized
                for (i = 0; i < 3; i++)
                    q.dir[i] = DIR_BITS'(longint'($urandom_range(0, 2 * UNIT)) - UNIT);
            end
        endcase
        for (i = 0; i < 3; i++)
            if ($urandom_range(0, 1) == 1)
                q.dir[i] = -q.dir[i];
        if ($urandom_range(0, 9) == 0)
            h = longint'($urandom_range(0, HMAX));
        else
            h = longint'($urandom_range(0, 4095));
        q.half = HALF_BITS'(h);
        span   = 3 * h + 1024;
        for (i = 0; i < 3; i++) begin
            off         = longint'($urandom_range(0, 2 * span)) - span;
            q.centre[i] = COORD_BITS'($urandom);
            q.point[i]  = COORD_BITS'(longint'($signed(q.centre[i])) + off);
        end
        return q;
    endfunction

    task automatic offer_query(input t_seg_query q, input bit known, input t_seg_disp want);
        while ($urandom_range(0, 99) < gap_pct) begin
            query_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        query_ch.valid       <= 1'b1;
        query_ch.point_x     <= q.point[0];
        query_ch.point_y     <= q.point[1];
        query_ch.point_z     <= q.point[2];
        query_ch.centre_x    <= q.centre[0];
        query_ch.centre_y    <= q.centre[1];
        query_ch.centre_z    <= q.centre[2];
        query_ch.dir_x       <= q.dir[0];
        query_ch.dir_y       <= q.dir[1];
        query_ch.dir_z       <= q.dir[2];
        query_ch.half_length <= q.half;
        @(posedge i_clk);
        while (!query_ch.ready)
            @(posedge i_clk);
        queue_result(known ? want : nearest_disp(q));
    endtask

    task automatic random_burst(input int count);
        repeat (count)
            offer_query(random_query(), 1'b0, '0);
    endtask

    // sender pauses until every outstanding result has come back
    task automatic drain_results();
        query_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (disp_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_pace(input t_pace pace);
        gap_pct   = (pace == PACE_SENDER_GAPS) ? 64 : (pace == PACE_BOTH) ? 10 : 0;
        stall_pct = (pace == PACE_SINK_STALLS) ? 64 : (pace == PACE_BOTH) ? 10 : 0;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        query_ch.valid       <= 1'b0;
        query_ch.point_x     <= '0;
        query_ch.point_y     <= '0;
        query_ch.point_z     <= '0;
        query_ch.centre_x    <= '0;
        query_ch.centre_y    <= '0;
        query_ch.centre_z    <= '0;
        query_ch.dir_x       <= '0;
        query_ch.dir_y       <= '0;
        query_ch.dir_z       <= '0;
        query_ch.half_length <= '0;
        set_pace(PACE_FREE);

        // all zero: t == 0 lands in the interior
        add_probe(known_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                            0, 0, 0, REG_INTERIOR));
        // zero half-length: displacement is v, region follows the sign of t; then h = 1024 in each region
        add_probe(known_row(make_query(256, 0, 0, 0, 0, 0, UNIT, 0, 0, 0),
                            256, 0, 0, REG_END));
        add_probe(known_row(make_query(-256, 0, 0, 0, 0, 0, UNIT, 0, 0, 0),
                            -256, 0, 0, REG_START));
        add_probe(known_row(make_query(0, 512, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            0, 512, 0, REG_INTERIOR));
        add_probe(known_row(make_query(4096, 0, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            3072, 0, 0, REG_END));
        add_probe(known_row(make_query(-4096, 0, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            -3072, 0, 0, REG_START));
        // t exactly at 2h stays interior; one LSB past it is the end region
        add_probe(known_row(make_query(1024, 0, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            0, 0, 0, REG_INTERIOR));
        add_probe(known_row(make_query(1025, 0, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            1, 0, 0, REG_END));
        add_probe(known_row(make_query(-1025, 0, 0, 0, 0, 0, UNIT, 0, 0, 1024),
                            -1, 0, 0, REG_START));
        // h*dir rounding: +0.5 rounds up, -0.5 rounds to zero
        add_probe(known_row(make_query(0, 0, 0, 0, 0, 0, UNIT / 2, 0, 0, 1),
                            1, 0, 0, REG_INTERIOR));
        add_probe(known_row(make_query(0, 0, 0, 0, 0, 0, -UNIT / 2, 0, 0, 1),
                            0, 0, 0, REG_INTERIOR));
        // coordinate extremes with a null direction
        add_probe(known_row(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                       0, 0, 0, 0),
                            CMAX - CMIN, CMAX - CMIN, CMAX - CMIN, REG_INTERIOR));
        add_probe(known_row(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                       0, 0, 0, HMAX),
                            CMIN - CMAX, CMIN - CMAX, CMIN - CMAX, REG_INTERIOR));
        // longest half-length along z, query at the centre
        add_probe(known_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, UNIT, HMAX),
                            0, 0, 0, REG_INTERIOR));
        // direction extremes, a non-unit direction and two unit directions
        add_probe(predicted_row(make_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                           -32768, -32768, -32768, HMAX)));
        add_probe(predicted_row(make_query(0, 0, 0, 0, 0, 0,
                                           32767, 32767, 32767, HMAX)));
        add_probe(predicted_row(make_query(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
                                           32767, -32768, 32767, HMAX)));
        add_probe(predicted_row(make_query(500, 70, -30, 0, 0, 0,
                                           UNIT / 2, 0, 0, 1000)));
        add_probe(predicted_row(make_query(3000, 2000, 1000, 100, -100, 50,
                                           9459, 9459, 9459, 2048)));
        add_probe(predicted_row(make_query(100, -3000, 50, 0, 0, 0,
                                           0, -UNIT, 0, 4096)));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[n])
            offer_query(probe_rows[n].query, probe_rows[n].known, probe_rows[n].want);
        random_burst(320);

        // receiver holds off while queries keep coming, so the pipeline backs up
        hold_req = 1'b1;
        random_burst(40);
        drain_results();

        set_pace(PACE_SENDER_GAPS);
        random_burst(300);
        drain_results();
        set_pace(PACE_SINK_STALLS);
        random_burst(300);
        drain_results();
        set_pace(PACE_BOTH);
        random_burst(300);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS closest_point_on_segment_core");
        else
            $display("FAIL closest_point_on_segment_core");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        int hold_left;
        hold_left = 0;
        disp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 80;
            end
            if (hold_left != 0) begin
                hold_left--;
                disp_ch.ready <= 1'b0;
            end else begin
                disp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_seg_disp want;
        if (i_rst_n && disp_ch.valid && disp_ch.ready) begin
            if (disp_due.size() == 0) begin
                report_mismatch("result transfer with no query pending, region",
                                longint'(disp_ch.region), 0);
            end else begin
                want = disp_due.pop_front();
                if (disp_ch.disp_x !== want.disp[0])
                    report_mismatch($sformatf("result %0d disp_x", results_seen),
                                    longint'($signed(disp_ch.disp_x)),
                                    longint'($signed(want.disp[0])));
                if (disp_ch.disp_y !== want.disp[1])
                    report_mismatch($sformatf("result %0d disp_y", results_seen),
                                    longint'($signed(disp_ch.disp_y)),
                                    longint'($signed(want.disp[1])));
                if (disp_ch.disp_z !== want.disp[2])
                    report_mismatch($sformatf("result %0d disp_z", results_seen),
                                    longint'($signed(disp_ch.disp_z)),
                                    longint'($signed(want.disp[2])));
                if (disp_ch.region !== want.region)
                    report_mismatch($sformatf("result %0d region", results_seen),
                                    longint'(disp_ch.region), longint'(want.region));
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("FAIL closest_point_on_segment_core");
        $finish;
    end

endmodule

[closest_point_on_segment_core.f]
+incdir+hdl
hdl/cps_pkg.sv
hdl/cps_if.sv
hdl/cps_front.sv
hdl/cps_proj.sv
hdl/cps_back.sv
hdl/closest_point_on_segment_core.sv
tb/testbench.sv
